FILE: hdl/bht_pkg.sv
// shared types, constants and command/status structs for the bucketed hash table
package bht_pkg;

    // field widths
    localparam int KEY_W = 31;
    localparam int VAL_W = 32;
    localparam int OP_W  = 2;
    localparam int ST_W  = 2;

    // default geometry
    localparam int BUCKETS_DEF = 16;
    localparam int WAYS_DEF    = 4;

    // residue unit: reciprocal multiply, then multiply back and subtract
    localparam int MOD_STEPS = 2;
    localparam int STEP_W    = $clog2(MOD_STEPS);

    // request codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

    // status codes
    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_MISS = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL = 2'd2;

    // value reported when nothing is found
    localparam logic signed [VAL_W-1:0] NO_VALUE = -32'sd1;

    typedef struct packed {
        logic [OP_W-1:0]         req_type;
        logic [KEY_W-1:0]        key;
        logic signed [VAL_W-1:0] new_value;
    } req_t;

    typedef struct packed {
        logic [ST_W-1:0]         status;
        logic signed [VAL_W-1:0] found_value;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic clear;
        logic load;
        logic mod_step;
        logic read;
        logic compare;
        logic commit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
    } stat_t;

endpackage

FILE: hdl/bucketed_hash_table.sv
// top level: bucketed hash table with bounded chains, valid/ready request and result
// sequence: after the request transfer, two residue steps, a row read, a compare
//   and a commit; the commit waits only while an earlier result is not yet taken
// one request in flight: a new request is taken only once the last one has committed
// reset: synchronous active-low; a clearing pass then zeroes one bucket fill count
//   per cycle until every bucket is cleared, with no request taken until it ends
module bucketed_hash_table #(
    parameter int BUCKETS = bht_pkg::BUCKETS_DEF,
    parameter int WAYS    = bht_pkg::WAYS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  bht_pkg::req_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output bht_pkg::rsp_t m_data
);
    import bht_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // control
    bht_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // datapath
    bht_dp #(
        .BUCKETS(BUCKETS),
        .WAYS   (WAYS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .req     (s_data),
        .stat    (stat),
        .rsp     (m_data)
    );

`ifndef NO_ASSERTIONS
    // clearing pass holds off requests right after reset
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("request port open during clearing pass");

    // one request in flight at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second request taken while one is in flight");

    // a commit never overwrites a result not yet transferred
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!m_valid || m_ready))
        else $error("result register overwritten");

    // no request work while clearing
    a_clear_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear |-> !(cmd.load || cmd.read || cmd.commit))
        else $error("request work overlaps clearing pass");
`endif

endmodule

FILE: hdl/bht_mod.sv
// key modulo bucket-count unit: reciprocal multiply, then multiply back and subtract
module bht_mod #(
    parameter int BUCKETS = bht_pkg::BUCKETS_DEF
) (
    input  logic                       aclk,
    input  logic                       load,
    input  logic                       step,
    input  logic [bht_pkg::KEY_W-1:0]  key,
    output logic [$clog2(BUCKETS)-1:0] bucket
);
    import bht_pkg::*;

    localparam int BW      = $clog2(BUCKETS);
    localparam int SHIFT   = KEY_W + BW;
    localparam int RECIP_W = KEY_W + 1;
    localparam int PROD_W  = KEY_W + RECIP_W;
    localparam longint unsigned RECIP =
        ((64'd1 << SHIFT) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
    localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);
    localparam logic [KEY_W-1:0]   BKT     = KEY_W'(BUCKETS);

    logic [KEY_W-1:0]  key_reg, key_next;
    logic [KEY_W-1:0]  quo_reg, quo_next;
    logic [BW-1:0]     rem_reg, rem_next;
    logic [PROD_W-1:0] prod;
    logic [KEY_W-1:0]  back;

    // quotient by rounded-up reciprocal, exact over the whole key range
    assign prod = PROD_W'(key_reg) * PROD_W'(RECIP_C);

    // quotient times bucket count, from the previous step
    assign back = quo_reg * BKT;

    // first step forms the quotient, second step the remainder
    always_comb begin
        key_next = key_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        if (load) begin
            key_next = key;
        end else if (step) begin
            quo_next = KEY_W'(prod >> SHIFT);
            rem_next = BW'(key_reg - back);
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign bucket = rem_reg;

endmodule

FILE: hdl/bht_dp.sv
// datapath: bucket row memories, way compare, row update and result register
module bht_dp #(
    parameter int BUCKETS = bht_pkg::BUCKETS_DEF,
    parameter int WAYS    = bht_pkg::WAYS_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  bht_pkg::cmd_t  cmd,
    input  bht_pkg::req_t  req,
    output bht_pkg::stat_t stat,
    output bht_pkg::rsp_t  rsp
);
    import bht_pkg::*;

    localparam int BW = $clog2(BUCKETS);
    localparam int FW = $clog2(WAYS + 1);
    localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int KROW_W = WAYS * KEY_W;
    localparam int VROW_W = WAYS * VAL_W;

    // row memories, one row per bucket
    logic [KROW_W-1:0] key_mem [BUCKETS];
    logic [VROW_W-1:0] val_mem [BUCKETS];
    logic [FW-1:0]     fill_mem [BUCKETS];

    req_t              req_reg;
    logic [BW-1:0]     bucket;
    logic [BW-1:0]     clr_addr_reg;
    logic [KROW_W-1:0] rd_keys_reg;
    logic [VROW_W-1:0] rd_vals_reg;
    logic [FW-1:0]     rd_fill_reg;
    logic              hit_next, hit_reg;
    logic [WW-1:0]     pos_next, pos_reg;
    logic [KROW_W-1:0] new_keys;
    logic [VROW_W-1:0] new_vals;
    logic [FW-1:0]     new_fill;
    logic              row_we;
    rsp_t              rsp_next, rsp_reg;

    // bucket index
    bht_mod #(
        .BUCKETS(BUCKETS)
    ) u_mod (
        .aclk   (aclk),
        .load   (cmd.load),
        .step   (cmd.mod_step),
        .key    (req.key),
        .bucket (bucket)
    );

    // request capture
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg <= req;
        end
    end

    // clearing pass address
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clear) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    assign stat.clear_last = (clr_addr_reg == BW'(BUCKETS - 1));

    // memory read port, registered data
    always_ff @(posedge aclk) begin
        if (cmd.read) begin
            rd_keys_reg <= key_mem[bucket];
            rd_vals_reg <= val_mem[bucket];
            rd_fill_reg <= fill_mem[bucket];
        end
    end

    // oldest live way with a matching key
    always_comb begin
        hit_next = 1'b0;
        pos_next = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if ((FW'(w) < rd_fill_reg) && (rd_keys_reg[w*KEY_W +: KEY_W] == req_reg.key)) begin
                hit_next = 1'b1;
                pos_next = WW'(w);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.compare) begin
            hit_reg <= hit_next;
            pos_reg <= pos_next;
        end
    end

    // row update and result
    always_comb begin
        new_keys             = rd_keys_reg;
        new_vals             = rd_vals_reg;
        new_fill             = rd_fill_reg;
        row_we               = 1'b0;
        rsp_next.status      = ST_OK;
        rsp_next.found_value = NO_VALUE;
        case (req_reg.req_type)
            OP_INSERT: begin
                if (rd_fill_reg >= FW'(WAYS)) begin
                    rsp_next.status = ST_FULL;
                end else begin
                    // append at the end of the chain
                    for (int w = 0; w < WAYS; w++) begin
                        if (FW'(w) == rd_fill_reg) begin
                            new_keys[w*KEY_W +: KEY_W] = req_reg.key;
                            new_vals[w*VAL_W +: VAL_W] = req_reg.new_value;
                        end
                    end
                    new_fill = rd_fill_reg + 1'b1;
                    row_we   = 1'b1;
                end
            end
            OP_DELETE: begin
                if (!hit_reg) begin
                    rsp_next.status = ST_MISS;
                end else begin
                    // close the gap toward the front
                    for (int w = 0; w < WAYS - 1; w++) begin
                        if (WW'(w) >= pos_reg) begin
                            new_keys[w*KEY_W +: KEY_W] = rd_keys_reg[(w+1)*KEY_W +: KEY_W];
                            new_vals[w*VAL_W +: VAL_W] = rd_vals_reg[(w+1)*VAL_W +: VAL_W];
                        end
                    end
                    new_fill = rd_fill_reg - 1'b1;
                    row_we   = 1'b1;
                end
            end
            OP_SEARCH: begin
                if (!hit_reg) begin
                    rsp_next.status = ST_MISS;
                end else begin
                    for (int w = 0; w < WAYS; w++) begin
                        if (WW'(w) == pos_reg) begin
                            rsp_next.found_value = rd_vals_reg[w*VAL_W +: VAL_W];
                        end
                    end
                end
            end
            default: begin
                rsp_next.status = ST_OK;
            end
        endcase
    end

    // memory write port, shared by clearing pass and row update
    always_ff @(posedge aclk) begin
        if (cmd.clear) begin
            fill_mem[clr_addr_reg] <= '0;
        end else if (cmd.commit && row_we) begin
            key_mem[bucket]  <= new_keys;
            val_mem[bucket]  <= new_vals;
            fill_mem[bucket] <= new_fill;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

endmodule

FILE: hdl/bht_ctrl.sv
// controller: sequences the clearing pass after reset, then residue, read, compare and commit per request
module bht_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    input  bht_pkg::stat_t stat,
    output bht_pkg::cmd_t  cmd
);
    import bht_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_READ,
        S_CMP,
        S_WRITE
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              m_valid_reg, m_valid_next;

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            S_CLEAR: begin
                cmd.clear = 1'b1;
                if (stat.clear_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    state_next = S_MOD;
                end
            end
            S_MOD: begin
                cmd.mod_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_W'(MOD_STEPS - 1)) begin
                    state_next = S_READ;
                end
            end
            S_READ: begin
                cmd.read   = 1'b1;
                state_next = S_CMP;
            end
            S_CMP: begin
                cmd.compare = 1'b1;
                state_next  = S_WRITE;
            end
            S_WRITE: begin
                // commit only once the result register is free
                if (!m_valid_reg || m_ready) begin
                    cmd.commit   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

endmodule

FILE: sim/tb_top.sv
// testbench for the bucketed hash table: directed table, then random traffic checked by a predictor
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bht_pkg::*;

    localparam int NB = BUCKETS_DEF;
    localparam int NW = WAYS_DEF;
    localparam int RAND_ITEMS = 1230;
    localparam int TAIL_CYCLES = 24;
    localparam int HOLD_AFTER = 200;
    localparam int HOLD_CYCLES = 300;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};
    localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

    typedef struct {
        req_t req;
        bit   typed;
        rsp_t rsp;
    } dir_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    req_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    rsp_t m_data;

    // shadow table
    logic [KEY_W-1:0]        chain_key [NB*NW];
    logic signed [VAL_W-1:0] chain_val [NB*NW];
    int unsigned             chain_len [NB];

    rsp_t     pending_rsp[$];
    dir_row_t dir_rows[$];
    int       err_cnt = 0;
    int       rsp_cnt = 0;

    bucketed_hash_table #(
        .BUCKETS(NB),
        .WAYS   (NW)
    ) u_top (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    // clock
    initial begin
        forever #2 aclk = ~aclk;
    end

    // run limit
    initial begin
        #3_000_000;
        $display("Some tests failed");
        $finish;
    end

    // apply one request to the shadow table and return its response
    function automatic rsp_t apply_request(req_t r);
        int unsigned b;
        int unsigned n;
        int unsigned pos;
        int unsigned w;
        rsp_t rsp;
        b = r.key % NB;
        n = chain_len[b];
        rsp.status = ST_OK;
        rsp.found_value = NO_VALUE;
        pos = NW;
        for (w = 0; w < n; w++) begin
            if (pos == NW && chain_key[b*NW + w] == r.key)
                pos = w;
        end
        case (r.req_type)
            OP_INSERT: begin
                if (n >= NW) begin
                    rsp.status = ST_FULL;
                end else begin
                    chain_key[b*NW + n] = r.key;
                    chain_val[b*NW + n] = r.new_value;
                    chain_len[b] = n + 1;
                end
            end
            OP_DELETE: begin
                if (pos == NW) begin
                    rsp.status = ST_MISS;
                end else begin
                    // close the gap toward the front
                    for (w = pos; w + 1 < n; w++) begin
                        chain_key[b*NW + w] = chain_key[b*NW + w + 1];
                        chain_val[b*NW + w] = chain_val[b*NW + w + 1];
                    end
                    chain_len[b] = n - 1;
                end
            end
            OP_SEARCH: begin
                if (pos == NW)
                    rsp.status = ST_MISS;
                else
                    rsp.found_value = chain_val[b*NW + pos];
            end
            default: ;
        endcase
        return rsp;
    endfunction

    function automatic void add_row(logic [OP_W-1:0] op, logic [KEY_W-1:0] k,
                                    logic [VAL_W-1:0] v, bit typed,
                                    logic [ST_W-1:0] st, logic [VAL_W-1:0] fv);
        dir_row_t row;
        row.req.req_type = op;
        row.req.key = k;
        row.req.new_value = v;
        row.typed = typed;
        row.rsp.status = st;
        row.rsp.found_value = fv;
        dir_rows.push_back(row);
    endfunction

    // hold valid with the request until the transfer, then queue its response
    task automatic offer(req_t r, rsp_t rsp);
        s_data <= r;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_rsp.push_back(rsp);
    endtask

    // random sender gap: mostly none or short, a few long
    task automatic sender_gap(bit calm);
        int unsigned roll;
        int unsigned gap;
        roll = $urandom_range(0, 99);
        gap = 0;
        if (!calm) begin
            if (roll >= 92)
                gap = $urandom_range(8, 30);
            else if (roll >= 60)
                gap = $urandom_range(1, 3);
        end
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // compare one result transfer with the oldest expectation
    task automatic check_result(rsp_t got);
        rsp_t want;
        rsp_cnt++;
        if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected result status=%0d value=%0d", $time,
                     got.status, got.found_value);
            err_cnt++;
        end else begin
            want = pending_rsp.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status mismatch expected %0d actual %0d", $time,
                         want.status, got.status);
                err_cnt++;
            end
            if (got.found_value !== want.found_value) begin
                $display("%0t: found_value mismatch expected %0d actual %0d", $time,
                         want.found_value, got.found_value);
                err_cnt++;
            end
        end
    endtask

    // receiver: random stalls, calm stretches and one long hold-off
    int unsigned stall_left = 0;
    int unsigned rx_cyc = 0;
    bit          hold_done = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else begin
            rx_cyc++;
            if (m_valid && m_ready)
                check_result(m_data);
            if (stall_left != 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!hold_done && rsp_cnt >= HOLD_AFTER) begin
                hold_done = 1'b1;
                stall_left = HOLD_CYCLES - 1;
                m_ready <= 1'b0;
            end else if ((rx_cyc / 1000) % 3 == 0 || $urandom_range(0, 99) < 70) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                if ($urandom_range(0, 99) < 85)
                    stall_left = $urandom_range(0, 2);
                else
                    stall_left = $urandom_range(9, 29);
            end
        end
    end

    // stimulus
    initial begin
        req_t        r;
        rsp_t        pred;
        int unsigned b;
        int unsigned ins_pct;
        int unsigned roll;
        int unsigned upper;
        bit          calm;

        foreach (chain_len[i]) chain_len[i] = 0;

        // directed table: bucket 0 chain filled with keys 0, 16, 0, 32, then key 48 refused as full
        add_row(OP_SEARCH, 31'd0,  32'hdead_beef, 1, ST_MISS, NO_VALUE);
        add_row(OP_DELETE, 31'd0,  32'h0000_0000, 1, ST_MISS, NO_VALUE);
        add_row(OP_UNUSED, 31'd0,  32'h0000_0000, 1, ST_OK,   NO_VALUE);
        add_row(OP_INSERT, 31'd0,  VAL_MIN,       1, ST_OK,   NO_VALUE);
        add_row(OP_INSERT, 31'd16, VAL_MAX,       1, ST_OK,   NO_VALUE);
        add_row(OP_INSERT, 31'd0,  32'd5,         1, ST_OK,   NO_VALUE);
        add_row(OP_INSERT, 31'd32, 32'hffff_ffff, 1, ST_OK,   NO_VALUE);
        add_row(OP_INSERT, 31'd48, 32'd1,         1, ST_FULL, NO_VALUE);
        add_row(OP_SEARCH, 31'd0,  32'h1234_5678, 0, ST_OK,   NO_VALUE);
        add_row(OP_SEARCH, 31'd32, 32'h0000_0000, 0, ST_OK,   NO_VALUE);
        add_row(OP_SEARCH, 31'd48, 32'h0000_0000, 1, ST_MISS, NO_VALUE);
        add_row(OP_DELETE, 31'd16, 32'hffff_ffff, 1, ST_OK,   NO_VALUE);
        add_row(OP_SEARCH, 31'd32, 32'h0000_0000, 0, ST_OK,   NO_VALUE);
        add_row(OP_DELETE, 31'd0,  32'h0000_0000, 1, ST_OK,   NO_VALUE);
        add_row(OP_SEARCH, 31'd0,  32'h0000_0000, 0, ST_OK,   NO_VALUE);
        add_row(OP_INSERT, KEY_MAX, 32'd0,        1, ST_OK,   NO_VALUE);
        add_row(OP_SEARCH, KEY_MAX, 32'd0,        0, ST_OK,   NO_VALUE);
        add_row(OP_UNUSED, KEY_MAX, 32'hffff_ffff, 1, ST_OK,  NO_VALUE);
        add_row(OP_DELETE, KEY_MAX, 32'd0,        1, ST_OK,   NO_VALUE);
        add_row(OP_DELETE, KEY_MAX, 32'd0,        1, ST_MISS, NO_VALUE);
        add_row(OP_SEARCH, KEY_MAX, 32'd0,        1, ST_MISS, NO_VALUE);
        add_row(OP_INSERT, 31'd48, 32'h0000_1234, 1, ST_OK,   NO_VALUE);
        add_row(OP_DELETE, 31'd48, 32'd0,         1, ST_OK,   NO_VALUE);
        add_row(OP_SEARCH, 31'd64, 32'd0,         1, ST_MISS, NO_VALUE);

        // reset
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part
        foreach (dir_rows[i]) begin
            pred = apply_request(dir_rows[i].req);
            offer(dir_rows[i].req, dir_rows[i].typed ? dir_rows[i].rsp : pred);
            sender_gap(i < 8);
        end

        // random part: insert weight changes every 100 requests to fill and drain chains
        ins_pct = 50;
        for (int i = 0; i < RAND_ITEMS; i++) begin
            if (i % 100 == 0)
                ins_pct = $urandom_range(15, 65);
            calm = ((i / 100) % 4 == 0);

            // hot buckets most of the time so chains fill up
            if ($urandom_range(0, 99) < 70)
                b = $urandom_range(0, 3);
            else
                b = $urandom_range(0, NB - 1);
            if ($urandom_range(0, 99) < 70)
                upper = $urandom_range(0, 5);
            else
                upper = $urandom_range(0, (1 << (KEY_W - 4)) - 1);

            roll = $urandom_range(0, 99);
            if (roll < 4)
                r.req_type = OP_UNUSED;
            else if (roll < 4 + ins_pct)
                r.req_type = OP_INSERT;
            else if (roll % 2 == 0)
                r.req_type = OP_DELETE;
            else
                r.req_type = OP_SEARCH;

            r.key = KEY_W'(upper * NB + b);
            // delete and search mostly hit a key that is in the chain
            if (r.req_type != OP_INSERT && chain_len[b] != 0 && $urandom_range(0, 99) < 65)
                r.key = chain_key[b*NW + $urandom_range(0, chain_len[b] - 1)];

            roll = $urandom_range(0, 99);
            if (roll < 5)
                r.new_value = VAL_MIN;
            else if (roll < 10)
                r.new_value = VAL_MAX;
            else
                r.new_value = $urandom;

            pred = apply_request(r);
            offer(r, pred);
            sender_gap(calm);
        end
        s_valid <= 1'b0;

        // drain
        while (pending_rsp.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (err_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: bucketed_hash_table.f
hdl/bht_pkg.sv
hdl/bht_mod.sv
hdl/bht_dp.sv
hdl/bht_ctrl.sv
hdl/bucketed_hash_table.sv
sim/tb_top.sv
